// ===== rtl/cpa_pkg.sv =====
// Package: pixel mode codes, register map and conversion constants.
`default_nettype none
package cpa_pkg;

	typedef enum logic [1:0] {
		MODE_BGRA  = 2'd0,
		MODE_UYVY  = 2'd1,
		MODE_TEN   = 2'd2,
		MODE_RAW   = 2'd3
	} pix_mode_t;

	localparam pix_mode_t MODE_RESET = MODE_UYVY;

	localparam int unsigned PADDR_W = 3;
	localparam logic [PADDR_W-1:0] ADDR_PIXEL_MODE = 3'd0;

	localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;

	// BT.601 studio-range coefficients, 8 fractional bits
	localparam logic signed [19:0] K_Y   = 20'sd298;
	localparam logic signed [19:0] K_RV  = 20'sd409;
	localparam logic signed [19:0] K_GU  = 20'sd100;
	localparam logic signed [19:0] K_GV  = 20'sd208;
	localparam logic signed [19:0] K_BU  = 20'sd516;
	localparam logic signed [19:0] K_RND = 20'sd128;
	localparam logic signed [8:0]  Y_OFS = 9'sd16;
	localparam logic signed [8:0]  C_OFS = 9'sd128;

endpackage
`default_nettype wire

// ===== rtl/cpa_cfg_regs.sv =====
// APB register block holding the pixel mode.
`default_nettype none
module cpa_cfg_regs
	import cpa_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	output pix_mode_t               mode
);

	pix_mode_t mode_q;
	logic      wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr == ADDR_PIXEL_MODE);
	assign mode   = mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
		end else if (wr_en) begin
			mode_q <= pix_mode_t'(pwdata[1:0]);
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr == ADDR_PIXEL_MODE) begin
			prdata = {30'd0, mode_q};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/cpa_yuv2rgb.sv =====
// Single-pixel integer BT.601 YUV to opaque ARGB converter.
`default_nettype none
module cpa_yuv2rgb
	import cpa_pkg::*;
(
	input  wire logic [7:0] y,
	input  wire logic [7:0] u,
	input  wire logic [7:0] v,
	output logic [31:0]     argb
);

	logic signed [8:0]  c9, d9, e9;
	logic signed [19:0] c, d, e;
	logic signed [19:0] r_sum, g_sum, b_sum;
	logic [7:0]         r, g, b;

	function automatic logic [7:0] clamp8(input logic signed [19:0] s);
		logic [7:0] res;
		if (s[19]) begin
			res = 8'd0;
		end else if (|s[18:16]) begin
			res = 8'hFF;
		end else begin
			res = s[15:8];
		end
		return res;
	endfunction

	always_comb begin
		c9 = $signed({1'b0, y}) - Y_OFS;
		d9 = $signed({1'b0, u}) - C_OFS;
		e9 = $signed({1'b0, v}) - C_OFS;
		c  = {{11{c9[8]}}, c9};
		d  = {{11{d9[8]}}, d9};
		e  = {{11{e9[8]}}, e9};
		r_sum = c * K_Y + e * K_RV + K_RND;
		g_sum = c * K_Y - d * K_GU - e * K_GV + K_RND;
		b_sum = c * K_Y + d * K_BU + K_RND;
		r = clamp8(r_sum);
		g = clamp8(g_sum);
		b = clamp8(b_sum);
		argb = {8'hFF, r, g, b};
	end

endmodule
`default_nettype wire

// ===== rtl/capture_pixel_to_argb.sv =====
// Top level: captured word to ARGB pixel converter with APB mode register.
// Path: an accepted word enters the input register, and each of its pixels then the result register.
// Throughput: 1 word per cycle while out_ready holds, in BGRA, raw and ten-bit modes and for
// UYVY words with one pixel; a UYVY word with two pixels holds the input stage for both
// pixels, set by the one-pixel-per-cycle result register sharing a single converter.
// Reset: arst_n clears both valid flags and sets the mode to UYVY.
`default_nettype none
module capture_pixel_to_argb
	import cpa_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// APB config
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	// input words
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [31:0]        packed_word,
	input  wire logic               emit_second,
	input  wire logic               frame_end,
	// output pixels
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [31:0]             argb,
	output logic                    last_of_item,
	output logic                    frame_last
);

	pix_mode_t mode;

	// input stage: one captured word plus which pixel of it goes next
	logic        valid_s1;
	logic [31:0] word_s1;
	logic        second_s1;
	logic        fend_s1;
	pix_mode_t   mode_s1;
	logic        phase_s1;    // 0: Y0 pixel next, 1: Y1 pixel next

	// result register
	logic        valid_s2;
	logic [31:0] argb_s2;
	logic        last_s2;
	logic        flast_s2;

	logic        in_acc;
	logic        out_load;
	logic        pix_last;
	logic [7:0]  y_sel;
	logic [31:0] yuv_argb;
	logic [31:0] pix;

	cpa_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.mode    (mode)
	);

	// UYVY word: U in byte 0, Y0 byte 1, V byte 2, Y1 byte 3
	assign y_sel = phase_s1 ? word_s1[31:24] : word_s1[15:8];

	cpa_yuv2rgb u_conv (
		.y    (y_sel),
		.u    (word_s1[7:0]),
		.v    (word_s1[23:16]),
		.argb (yuv_argb)
	);

	always_comb begin
		case (mode_s1)
			MODE_BGRA: pix = word_s1;             // BGRA bytes already land as ARGB
			MODE_UYVY: pix = yuv_argb;
			MODE_TEN:  pix = 32'd0;
			MODE_RAW:  pix = word_s1 | ALPHA_OPAQUE;
			default:   pix = 32'd0;
		endcase
	end

	// last pixel of the word: non-UYVY, no second pixel, or already on Y1
	assign pix_last = (mode_s1 != MODE_UYVY) || !second_s1 || phase_s1;

	// result register free or draining this cycle
	assign out_load = valid_s1 && (!valid_s2 || out_ready);

	// take a new word when the input stage is empty or hands off its last pixel
	assign in_ready = !valid_s1 || (out_load && pix_last);
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
			phase_s1 <= 1'b0;
		end else if (out_load) begin
			if (pix_last) begin
				valid_s1 <= 1'b0;
			end else begin
				phase_s1 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			word_s1   <= packed_word;
			second_s1 <= emit_second;
			fend_s1   <= frame_end;
			mode_s1   <= mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_load) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			argb_s2  <= pix;
			last_s2  <= pix_last;
			flast_s2 <= pix_last && fend_s1;
		end
	end

	assign out_valid    = valid_s2;
	assign argb         = argb_s2;
	assign last_of_item = last_s2;
	assign frame_last   = flast_s2;

endmodule
`default_nettype wire

// ===== rtl/cpa_checker.sv =====
// Port-level checker for the pixel converter, bound to the top level.
`default_nettype none
module cpa_checker
	import cpa_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               psel,
	input wire logic               penable,
	input wire logic               pready,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic [31:0]        packed_word,
	input wire logic               emit_second,
	input wire logic               frame_end,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [31:0]        argb,
	input wire logic               last_of_item,
	input wire logic               frame_last
);

	// frame end only ever rides on the final pixel of a word
	a_flast_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> last_of_item)
		else $error("frame_last without last_of_item");

	// back-pressure on input comes from a full result register or a two-pixel UYVY word
	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> out_valid)
		else $error("input stalled while no pixel pending");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(argb) && $stable(last_of_item)
			&& $stable(frame_last))
		else $error("pending pixel changed before taken");

	// a waiting input word stays up with its payload frozen
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(packed_word) && $stable(emit_second)
			&& $stable(frame_end))
		else $error("waiting input word changed before taken");

	a_apb_ready: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable |-> pready)
		else $error("APB access without pready");

endmodule

bind capture_pixel_to_argb cpa_checker u_cpa_checker (.*);
`default_nettype wire
